// ===== hw/rtl/i2c_transfer_command_sequencer_core_macros.svh =====
// ----------------------------------------------------------------------------
// I2C command sequencer assertion macros
// Shared concurrent assertion forms, clocked on i_clk, held off in reset.
// ----------------------------------------------------------------------------
`ifndef I2C_TRANSFER_COMMAND_SEQUENCER_CORE_MACROS_SVH
`define I2C_TRANSFER_COMMAND_SEQUENCER_CORE_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ICS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// The condition must never be true at a clock edge outside reset.
`define ICS_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`endif

// ===== hw/rtl/ics_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C command sequencer package
// Types, codes and helpers shared by the sequencer modules.
// ----------------------------------------------------------------------------
package ics_pkg;

    localparam int MAX_MSGS_DEF     = 16;
    localparam int TX_BUF_BYTES_DEF = 256;
    localparam int CHUNK_MAX_DEF    = 256;
    localparam int Q_DEPTH          = 2;
    localparam int IN_TDATA_W       = 40;
    localparam int OUT_TDATA_W      = 32;

    // Request kinds.
    localparam logic [2:0] K_LOAD_DESC = 3'd0;
    localparam logic [2:0] K_LOAD_TX   = 3'd1;
    localparam logic [2:0] K_START     = 3'd2;
    localparam logic [2:0] K_EVENT     = 3'd3;
    localparam logic [2:0] K_RX        = 3'd4;

    // Controller command codes.
    localparam logic [2:0] CMD_TX    = 3'd0;
    localparam logic [2:0] CMD_RX    = 3'd1;
    localparam logic [2:0] CMD_STOP  = 3'd2;
    localparam logic [2:0] CMD_START = 3'd4;

    // Interrupt sets.
    localparam logic [1:0] WAIT_TX   = 2'd0;
    localparam logic [1:0] WAIT_STOP = 2'd1;
    localparam logic [1:0] WAIT_RX   = 2'd2;

    // Completion status.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_ACK  = 2'd1;
    localparam logic [1:0] ST_SERIOUS = 2'd2;
    localparam logic [1:0] ST_FLAGS   = 2'd3;

    typedef struct packed {
        logic [15:0] length;
        logic        no_start;
        logic        want_stop;
        logic        is_read;
        logic [6:0]  addr;
    } t_desc;

    typedef struct packed {
        logic [2:0] kind;
        logic       ev_tx_ready;
        logic       ev_serious;
        logic       ev_no_ack;
        logic [7:0] data_byte;
        t_desc      desc;
    } t_item;

    typedef struct packed {
        logic [4:0] pad;
        logic [1:0] wait_events;
        logic       reinit_request;
        logic [1:0] status;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       rx_valid;
        logic [7:0] cmd_data;
        logic [2:0] cmd_code;
        logic       cmd_valid;
    } t_result;

    typedef struct packed {
        logic valid;
        logic full;
    } t_q_stat;

    typedef struct packed {
        logic res_we;
        logic out_full;
    } t_bk_stat;

    function automatic t_result mk_cmd(logic [2:0] code, logic [7:0] data, logic [1:0] wt);
        t_result r;
        r             = '0;
        r.cmd_valid   = 1'b1;
        r.cmd_code    = code;
        r.cmd_data    = data;
        r.wait_events = wt;
        return r;
    endfunction

    function automatic t_result mk_done(logic [1:0] st, logic reinit);
        t_result r;
        r                = '0;
        r.done_res       = 1'b1;
        r.status         = st;
        r.reinit_request = reinit;
        return r;
    endfunction

endpackage

// ===== hw/rtl/ics_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ics_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/ics_front.sv =====
// ----------------------------------------------------------------------------
// Sequencer front end
// Accepts requests, drops unused kinds and queues the rest for the back end.
// ----------------------------------------------------------------------------
module ics_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [ics_pkg::IN_TDATA_W-1:0]  i_data,
    input  logic [2:0]                      i_kind,
    input  logic                            i_pop,
    output ics_pkg::t_item                  o_item,
    output ics_pkg::t_q_stat                o_stat
);
    import ics_pkg::*;

    localparam int QW = $clog2(Q_DEPTH);

    t_item           r_mem [Q_DEPTH];
    logic [QW-1:0]   r_wp, r_rp;
    logic [QW:0]     r_cnt;
    logic            w_push, w_known;
    t_item           w_item;

    // Kinds above the rx byte have no effect and are not queued.
    always_comb begin
        unique case (i_kind) inside
            K_LOAD_DESC, K_LOAD_TX, K_START, K_EVENT, K_RX: w_known = 1'b1;
            default: w_known = 1'b0;
        endcase
    end

    always_comb begin
        w_item             = '0;
        w_item.kind        = i_kind;
        w_item.desc        = i_data[25:0];
        w_item.data_byte   = i_data[33:26];
        w_item.ev_no_ack   = i_data[34];
        w_item.ev_serious  = i_data[35];
        w_item.ev_tx_ready = i_data[36];
    end

    assign o_stat.full  = (r_cnt == (QW+1)'(Q_DEPTH));
    assign o_stat.valid = (r_cnt != '0);
    assign o_ready      = !o_stat.full;
    assign w_push       = i_valid && o_ready && w_known;
    assign o_item       = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= w_item;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == QW'(Q_DEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == QW'(Q_DEPTH-1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (QW+1)'(w_push) - (QW+1)'(i_pop);
        end
    end
endmodule

// ===== hw/rtl/ics_back.sv =====
// ----------------------------------------------------------------------------
// Sequencer back end
// Holds descriptors and transmit bytes and turns events into commands.
// ----------------------------------------------------------------------------
module ics_back #(
    parameter int MAX_MSGS     = ics_pkg::MAX_MSGS_DEF,
    parameter int TX_BUF_BYTES = ics_pkg::TX_BUF_BYTES_DEF,
    parameter int CHUNK_MAX    = ics_pkg::CHUNK_MAX_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ics_pkg::t_item      i_item,
    input  ics_pkg::t_q_stat    i_q,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output ics_pkg::t_result    o_result,
    output ics_pkg::t_bk_stat   o_stat
);
    import ics_pkg::*;

    localparam int CW = $clog2(MAX_MSGS + 1);
    localparam int AW = (MAX_MSGS > 1) ? $clog2(MAX_MSGS) : 1;
    localparam int PW = $clog2(TX_BUF_BYTES);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_CHK   = 3'd2;
    localparam logic [2:0] S_NMSG  = 3'd3;
    localparam logic [2:0] S_NDESC = 3'd4;
    localparam logic [2:0] S_TXUSE = 3'd5;

    logic [2:0]   r_state, n_state;
    t_item        r_item, n_item;
    logic [CW-1:0] r_cnt, n_cnt, r_idx, n_idx;
    logic [PW-1:0] r_ldp, n_ldp, r_rdp, n_rdp;
    logic [15:0]  r_chunk, n_chunk, r_bytes, n_bytes;
    logic         r_stop, n_stop, r_reading, n_reading, r_active, n_active;
    logic         r_out_valid, n_out_valid;
    t_result      r_out, n_out;

    logic          desc_we, tx_we;
    logic [AW-1:0] desc_raddr;
    logic [PW-1:0] tx_raddr;
    t_desc         desc_q;
    logic [7:0]    tx_q;
    logic [15:0]   w_rx_n, w_d_rx_n;

    ics_ram #(.WIDTH($bits(t_desc)), .DEPTH(MAX_MSGS), .AW(AW)) u_desc_ram (
        .i_clk(i_clk), .i_we(desc_we), .i_waddr(r_cnt[AW-1:0]),
        .i_wdata(r_item.desc), .i_raddr(desc_raddr), .o_rdata(desc_q)
    );

    ics_ram #(.WIDTH(8), .DEPTH(TX_BUF_BYTES), .AW(PW)) u_tx_ram (
        .i_clk(i_clk), .i_we(tx_we), .i_waddr(r_ldp),
        .i_wdata(r_item.data_byte), .i_raddr(tx_raddr), .o_rdata(tx_q)
    );

    function automatic logic [PW-1:0] ring_next(logic [PW-1:0] p);
        return (p == PW'(TX_BUF_BYTES-1)) ? '0 : p + 1'b1;
    endfunction

    // Receive chunk sizes for the running message and for a freshly read one.
    assign w_rx_n   = (r_chunk < 16'(CHUNK_MAX)) ? r_chunk : 16'(CHUNK_MAX);
    assign w_d_rx_n = (desc_q.length < 16'(CHUNK_MAX)) ? desc_q.length : 16'(CHUNK_MAX);

    always_comb begin
        logic fin;
        logic [1:0] fin_st;
        logic fin_re;
        fin        = 1'b0;
        fin_st     = ST_OK;
        fin_re     = 1'b0;
        n_state    = r_state;
        n_item     = r_item;
        n_cnt      = r_cnt;
        n_idx      = r_idx;
        n_ldp      = r_ldp;
        n_rdp      = r_rdp;
        n_chunk    = r_chunk;
        n_bytes    = r_bytes;
        n_stop     = r_stop;
        n_reading  = r_reading;
        n_active   = r_active;
        n_out      = r_out;
        n_out_valid = r_out_valid && !i_ready;
        o_pop      = 1'b0;
        desc_we    = 1'b0;
        tx_we      = 1'b0;
        desc_raddr = r_idx[AW-1:0];
        tx_raddr   = r_rdp;

        unique case (r_state)
            S_IDLE: begin
                if (i_q.valid && !r_out_valid) begin
                    o_pop   = 1'b1;
                    n_item  = i_item;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                case (r_item.kind)
                    K_LOAD_DESC: begin
                        if (!r_active && r_cnt < CW'(MAX_MSGS)) begin
                            desc_we = 1'b1;
                            n_cnt   = r_cnt + 1'b1;
                        end
                    end
                    K_LOAD_TX: begin
                        if (!r_active) begin
                            tx_we = 1'b1;
                            n_ldp = ring_next(r_ldp);
                        end
                    end
                    K_START: begin
                        if (!r_active) begin
                            n_idx = '0;
                            n_rdp = '0;
                            if (r_cnt == '0) begin
                                fin = 1'b1;
                            end else begin
                                desc_raddr = '0;
                                n_state    = S_CHK;
                            end
                        end
                    end
                    K_EVENT: begin
                        if (r_active) begin
                            if (r_item.ev_no_ack) begin
                                fin    = 1'b1;
                                fin_st = ST_NO_ACK;
                            end else if (r_item.ev_serious) begin
                                fin    = 1'b1;
                                fin_st = ST_SERIOUS;
                                fin_re = 1'b1;
                            end else if (r_item.ev_tx_ready &&
                                         (!r_reading || r_chunk != '0 || r_bytes == '0)) begin
                                if (r_chunk != '0) begin
                                    if (r_reading) begin
                                        n_chunk     = r_chunk - w_rx_n;
                                        n_out       = mk_cmd(CMD_RX, 8'(w_rx_n - 16'd1), WAIT_RX);
                                        n_out_valid = 1'b1;
                                    end else begin
                                        n_rdp   = ring_next(r_rdp);
                                        n_bytes = (r_bytes != '0) ? r_bytes - 16'd1 : r_bytes;
                                        n_chunk = r_chunk - 16'd1;
                                        n_state = S_TXUSE;
                                    end
                                end else if (r_stop) begin
                                    n_stop      = 1'b0;
                                    n_out       = mk_cmd(CMD_STOP, 8'd0, WAIT_STOP);
                                    n_out_valid = 1'b1;
                                end else begin
                                    n_state = S_NMSG;
                                end
                            end
                        end
                    end
                    K_RX: begin
                        if (r_active && r_reading && r_bytes != '0) begin
                            n_bytes           = r_bytes - 16'd1;
                            n_out             = '0;
                            n_out.rx_valid    = 1'b1;
                            n_out.rx_byte     = r_item.data_byte;
                            n_out_valid       = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            S_CHK: begin
                if (desc_q.no_start) begin
                    fin    = 1'b1;
                    fin_st = ST_FLAGS;
                end else begin
                    n_active = 1'b1;
                    n_state  = S_NMSG;
                end
            end
            S_NMSG: begin
                if (r_idx >= r_cnt) begin
                    fin = 1'b1;
                end else begin
                    n_state = S_NDESC;
                end
            end
            S_NDESC: begin
                n_state   = S_IDLE;
                n_reading = desc_q.is_read;
                n_chunk   = desc_q.length;
                n_bytes   = desc_q.length;
                n_stop    = desc_q.want_stop ||
                            (({1'b0, r_idx} + 1'b1) >= {1'b0, r_cnt});
                n_idx     = r_idx + 1'b1;
                if (!desc_q.no_start) begin
                    n_out       = mk_cmd(CMD_START, {desc_q.addr, desc_q.is_read}, WAIT_TX);
                    n_out_valid = 1'b1;
                end else if (desc_q.length != '0) begin
                    if (desc_q.is_read) begin
                        n_chunk     = desc_q.length - w_d_rx_n;
                        n_out       = mk_cmd(CMD_RX, 8'(w_d_rx_n - 16'd1), WAIT_RX);
                        n_out_valid = 1'b1;
                    end else begin
                        n_rdp   = ring_next(r_rdp);
                        n_bytes = desc_q.length - 16'd1;
                        n_chunk = desc_q.length - 16'd1;
                        n_state = S_TXUSE;
                    end
                end else if (n_stop) begin
                    n_stop      = 1'b0;
                    n_out       = mk_cmd(CMD_STOP, 8'd0, WAIT_STOP);
                    n_out_valid = 1'b1;
                end else begin
                    // Empty continuation without stop: walk on to the next one.
                    n_state = S_NMSG;
                end
            end
            S_TXUSE: begin
                n_out       = mk_cmd(CMD_TX, tx_q, WAIT_TX);
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase

        if (fin) begin
            n_active    = 1'b0;
            n_cnt       = '0;
            n_idx       = '0;
            n_ldp       = '0;
            n_chunk     = '0;
            n_bytes     = '0;
            n_stop      = 1'b0;
            n_reading   = 1'b0;
            n_out       = mk_done(fin_st, fin_re);
            n_out_valid = 1'b1;
            n_state     = S_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_out  <= n_out;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_idx       <= '0;
            r_ldp       <= '0;
            r_rdp       <= '0;
            r_chunk     <= '0;
            r_bytes     <= '0;
            r_stop      <= 1'b0;
            r_reading   <= 1'b0;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_idx       <= n_idx;
            r_ldp       <= n_ldp;
            r_rdp       <= n_rdp;
            r_chunk     <= n_chunk;
            r_bytes     <= n_bytes;
            r_stop      <= n_stop;
            r_reading   <= n_reading;
            r_active    <= n_active;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_result        = r_out;
    assign o_stat.res_we   = n_out_valid && !(r_out_valid && !i_ready);
    assign o_stat.out_full = r_out_valid && !i_ready;
endmodule

// ===== hw/rtl/i2c_transfer_command_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// I2C transfer command sequencer
// Turns loaded message descriptors into controller commands, at most one per request.
// ----------------------------------------------------------------------------
//  Channel   Direction  Contents
//  s_axis    in         tuser: kind; tdata: descriptor, byte and event flags
//  m_axis    out        tdata: command, rx byte and completion fields
//
//  In the back end a request passes the idle and execute states, plus the
//  transmit-use state when a transmit byte is read. Opening a message walks
//  the next-message and descriptor states per descriptor, after a check of
//  the first message on a start, since descriptor and tx reads are registered.
//  Reset is synchronous, active low, and clears all control state at once.
//  A two-entry queue lets the input side go on while a result waits.
// ----------------------------------------------------------------------------
module i2c_transfer_command_sequencer_core #(
    parameter int MAX_MSGS     = ics_pkg::MAX_MSGS_DEF,
    parameter int TX_BUF_BYTES = ics_pkg::TX_BUF_BYTES_DEF,
    parameter int CHUNK_MAX    = ics_pkg::CHUNK_MAX_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // addr, is_read, want_stop, no_start, length, data_byte,
    // ev_no_ack, ev_serious, ev_tx_ready, zero fill
    input  logic [ics_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    // kind
    input  logic [2:0]                       i_s_axis_tuser,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // cmd_valid, cmd_code, cmd_data, rx_valid, rx_byte, done_res,
    // status, reinit_request, wait_events, zero fill
    output logic [ics_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata
);
    import ics_pkg::*;

`include "i2c_transfer_command_sequencer_core_macros.svh"

    t_item    w_item;
    t_q_stat  w_q;
    t_bk_stat w_bk;
    t_result  w_res;
    logic     w_pop;

    ics_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_s_axis_tvalid), .o_ready(o_s_axis_tready),
        .i_data(i_s_axis_tdata), .i_kind(i_s_axis_tuser),
        .i_pop(w_pop), .o_item(w_item), .o_stat(w_q)
    );

    ics_back #(
        .MAX_MSGS(MAX_MSGS), .TX_BUF_BYTES(TX_BUF_BYTES), .CHUNK_MAX(CHUNK_MAX)
    ) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_item(w_item), .i_q(w_q), .o_pop(w_pop),
        .o_valid(o_m_axis_tvalid), .i_ready(i_m_axis_tready),
        .o_result(w_res), .o_stat(w_bk)
    );

    assign o_m_axis_tdata = w_res;

    `ICS_ASSERT(a_pop_needs_item, w_pop |-> w_q.valid, "pop from an empty queue")
    `ICS_NEVER(a_no_overwrite, w_bk.res_we && w_bk.out_full, "result overwrote a held result")
    `ICS_ASSERT(a_one_kind, o_m_axis_tvalid |-> $onehot({w_res.cmd_valid, w_res.rx_valid,
        w_res.done_res}), "result carries not exactly one kind")
endmodule

// ===== tb/sv/i2c_transfer_command_sequencer_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C transfer command sequencer testbench
// Loads message lists and transmit bytes, runs transfers with bus events and
// received bytes, and checks every command, byte and completion that comes out
// against a predictor of the sequencer kept inside this bench.
// ----------------------------------------------------------------------------
module i2c_transfer_command_sequencer_core_tb;
    import ics_pkg::*;

    localparam int CLK_HALF   = 6;
    localparam int WDOG_LIMIT = 4000;
    localparam int RAND_ITEMS = 1450;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_axis_tvalid;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata;
    logic [2:0]             i_s_axis_tuser;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;

    i2c_transfer_command_sequencer_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // Predicted sequencer state.
    t_desc      desc_mem [MAX_MSGS_DEF];
    logic [7:0] tx_mem [TX_BUF_BYTES_DEF];
    int         n_desc;
    int         msg_idx;
    logic [7:0] ld_ptr;
    logic [7:0] rd_ptr;
    int         chunk_left;
    int         bytes_left;
    bit         stop_due;
    bit         rd_mode;
    bit         busy;
    t_result    next_res;

    t_result    expected_results [$];
    int         n_items;
    int         n_results;
    int         n_cmds;
    int         n_rx;
    int         n_done;
    int         n_errors;
    bit         quiet;
    bit         hold_req;

    function automatic void issue(logic [2:0] code, logic [7:0] data, logic [1:0] wt);
        next_res             = '0;
        next_res.cmd_valid   = 1'b1;
        next_res.cmd_code    = code;
        next_res.cmd_data    = data;
        next_res.wait_events = wt;
    endfunction

    function automatic void end_transfer(logic [1:0] st, logic reinit);
        busy       = 1'b0;
        n_desc     = 0;
        msg_idx    = 0;
        ld_ptr     = '0;
        chunk_left = 0;
        bytes_left = 0;
        stop_due   = 1'b0;
        rd_mode    = 1'b0;
        next_res                = '0;
        next_res.done_res       = 1'b1;
        next_res.status         = st;
        next_res.reinit_request = reinit;
    endfunction

    function automatic void next_chunk();
        int n;
        if (rd_mode) begin
            n = (chunk_left < CHUNK_MAX_DEF) ? chunk_left : CHUNK_MAX_DEF;
            chunk_left -= n;
            issue(CMD_RX, 8'(n - 1), WAIT_RX);
        end else begin
            issue(CMD_TX, tx_mem[rd_ptr], WAIT_TX);
            rd_ptr = rd_ptr + 8'd1;
            if (bytes_left > 0) bytes_left--;
            chunk_left--;
        end
    endfunction

    // Opens the next message; empty no-start messages without stop are passed over.
    function automatic void open_message();
        t_desc d;
        forever begin
            if (msg_idx >= n_desc) begin
                end_transfer(ST_OK, 1'b0);
                return;
            end
            d          = desc_mem[msg_idx];
            rd_mode    = d.is_read;
            chunk_left = int'(d.length);
            bytes_left = int'(d.length);
            stop_due   = d.want_stop || (msg_idx + 1 >= n_desc);
            msg_idx++;
            if (!d.no_start) begin
                issue(CMD_START, {d.addr, d.is_read}, WAIT_TX);
                return;
            end
            if (chunk_left != 0) begin
                next_chunk();
                return;
            end
            if (stop_due) begin
                stop_due = 1'b0;
                issue(CMD_STOP, 8'd0, WAIT_STOP);
                return;
            end
        end
    endfunction

    function automatic bit predict_request(t_item it);
        next_res = '0;
        case (it.kind)
            K_LOAD_DESC: begin
                if (!busy && n_desc < MAX_MSGS_DEF) begin
                    desc_mem[n_desc] = it.desc;
                    n_desc++;
                end
                return 1'b0;
            end
            K_LOAD_TX: begin
                if (!busy) begin
                    tx_mem[ld_ptr] = it.data_byte;
                    ld_ptr = ld_ptr + 8'd1;
                end
                return 1'b0;
            end
            K_START: begin
                if (busy) return 1'b0;
                msg_idx = 0;
                rd_ptr  = '0;
                if (n_desc > 0 && desc_mem[0].no_start) begin
                    end_transfer(ST_FLAGS, 1'b0);
                    return 1'b1;
                end
                busy = 1'b1;
                open_message();
                return 1'b1;
            end
            K_EVENT: begin
                if (!busy) return 1'b0;
                if (it.ev_no_ack) begin
                    end_transfer(ST_NO_ACK, 1'b0);
                    return 1'b1;
                end
                if (it.ev_serious) begin
                    end_transfer(ST_SERIOUS, 1'b1);
                    return 1'b1;
                end
                if (it.ev_tx_ready && (!rd_mode || chunk_left > 0 || bytes_left == 0)) begin
                    if (chunk_left != 0) begin
                        next_chunk();
                    end else if (stop_due) begin
                        stop_due = 1'b0;
                        issue(CMD_STOP, 8'd0, WAIT_STOP);
                    end else begin
                        open_message();
                    end
                    return 1'b1;
                end
                return 1'b0;
            end
            K_RX: begin
                if (busy && rd_mode && bytes_left > 0) begin
                    bytes_left--;
                    next_res.rx_valid = 1'b1;
                    next_res.rx_byte  = it.data_byte;
                    return 1'b1;
                end
                return 1'b0;
            end
            default: return 1'b0;
        endcase
    endfunction

    // Offers one request, waits for it to be taken and records what it should cause.
    task automatic send_request(t_item it);
        if (!quiet) begin
            while ($urandom_range(99) < 18) begin
                i_s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {3'b000, it[36:0]};
        i_s_axis_tuser  <= it.kind;
        do @(posedge i_clk); while (!o_s_axis_tready);
        n_items++;
        if (predict_request(it)) expected_results.push_back(next_res);
    endtask

    task automatic send_kind(logic [2:0] k);
        t_item it;
        it      = t_item'(40'({$urandom, $urandom}));
        it.kind = k;
        send_request(it);
    endtask

    task automatic send_desc(logic [6:0] a, bit rd, bit stp, bit nst, logic [15:0] len);
        t_item it;
        it                = t_item'(40'({$urandom, $urandom}));
        it.kind           = K_LOAD_DESC;
        it.desc.addr      = a;
        it.desc.is_read   = rd;
        it.desc.want_stop = stp;
        it.desc.no_start  = nst;
        it.desc.length    = len;
        send_request(it);
    endtask

    task automatic send_event(bit nack, bit ser, bit rdy);
        t_item it;
        it             = t_item'(40'({$urandom, $urandom}));
        it.kind        = K_EVENT;
        it.ev_no_ack   = nack;
        it.ev_serious  = ser;
        it.ev_tx_ready = rdy;
        send_request(it);
    endtask

    // Drives an active transfer with ready events, received bytes, stray requests and aborts until it ends.
    task automatic drive_transfer(int abort_pct, int step_cap);
        int steps;
        int r;
        steps = 0;
        while (busy) begin
            r = $urandom_range(99);
            steps++;
            if (steps > step_cap) begin
                send_event(1'b1, 1'($urandom_range(1)), 1'($urandom_range(1)));
            end else if (r < abort_pct) begin
                send_event(1'($urandom_range(1)), 1'b1, 1'($urandom_range(1)));
            end else if (r < abort_pct + 6) begin
                send_kind(3'($urandom_range(7)));
            end else if (rd_mode && bytes_left > 0 && chunk_left == 0 && r < 92) begin
                send_kind(K_RX);
            end else begin
                send_event(1'b0, 1'b0, 1'b1);
            end
        end
    endtask

    function automatic logic [15:0] pick_length();
        int r;
        r = $urandom_range(99);
        if (r < 70) return 16'($urandom_range(4));
        if (r < 95) return 16'($urandom_range(20, 5));
        if (r < 98) return 16'($urandom_range(300, 250));
        return 16'($urandom);
    endfunction

    task automatic random_transfer();
        int nm;
        int nb;
        nm = ($urandom_range(19) == 0) ? 18 : $urandom_range(4, 1);
        for (int i = 0; i < nm; i++) begin
            send_desc(7'($urandom), 1'($urandom_range(1)), 1'($urandom_range(1)),
                      (i == 0) ? ($urandom_range(15) == 0) : ($urandom_range(3) == 0),
                      pick_length());
        end
        nb = $urandom_range(10);
        for (int i = 0; i < nb; i++) send_kind(K_LOAD_TX);
        send_kind(K_START);
        drive_transfer(2, 350);
    endtask

    // Every ring entry gets written at least once, so no transfer reads an unwritten byte.
    task automatic test_ring_preload();
        for (int i = 0; i < TX_BUF_BYTES_DEF; i++) send_kind(K_LOAD_TX);
        send_kind(K_LOAD_TX);
    endtask

    task automatic test_directed();
        send_kind(K_START);
        send_kind(K_EVENT);
        send_kind(K_RX);
        send_kind(3'd5);
        send_kind(3'd6);
        send_kind(3'd7);
        send_desc(7'h7F, 1'b0, 1'b0, 1'b1, 16'd2);
        send_kind(K_START);
        send_desc(7'h00, 1'b0, 1'b1, 1'b0, 16'd2);
        send_desc(7'h55, 1'b1, 1'b0, 1'b0, 16'd3);
        send_desc(7'h2A, 1'b0, 1'b0, 1'b1, 16'd0);
        send_kind(K_START);
        send_kind(K_START);
        send_kind(K_LOAD_DESC);
        drive_transfer(0, 100);
        send_desc(7'h7F, 1'b1, 1'b1, 1'b0, 16'hFFFF);
        send_kind(K_START);
        send_event(1'b0, 1'b0, 1'b1);
        send_event(1'b1, 1'b1, 1'b0);
        send_desc(7'h01, 1'b0, 1'b0, 1'b0, 16'd1);
        send_kind(K_START);
        send_event(1'b0, 1'b1, 1'b0);
    endtask

    // Runs without any idling on either side.
    task automatic test_list_overflow();
        quiet = 1'b1;
        for (int i = 0; i < MAX_MSGS_DEF + 2; i++) begin
            send_desc(7'($urandom), 1'($urandom_range(1)), 1'b0, 1'b0,
                      16'($urandom_range(1)));
        end
        send_kind(K_START);
        drive_transfer(0, 400);
        quiet = 1'b0;
    endtask

    task automatic test_backpressure();
        send_desc(7'h33, 1'b0, 1'b1, 1'b0, 16'd40);
        send_kind(K_START);
        hold_req = 1'b1;
        drive_transfer(0, 200);
    endtask

    task automatic test_random();
        while (n_items < RAND_ITEMS) begin
            quiet = ($urandom_range(9) == 0);
            random_transfer();
        end
        quiet = 1'b0;
    endtask

    // Result side: random stalls plus one long hold on request.
    int hold_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            hold_left       = 0;
        end else begin
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= quiet || ($urandom_range(99) >= 18);
            end
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = t_result'(o_m_axis_tdata);
            n_results++;
            if (expected_results.size() == 0) begin
                n_errors++;
                if (n_errors <= 10) $display("ERROR: unexpected result %h", got);
            end else begin
                want = expected_results.pop_front();
                if (got.cmd_valid) n_cmds++;
                if (got.rx_valid) n_rx++;
                if (got.done_res) n_done++;
                if (got.cmd_valid != want.cmd_valid || got.cmd_code != want.cmd_code ||
                    got.cmd_data != want.cmd_data || got.rx_valid != want.rx_valid ||
                    got.rx_byte != want.rx_byte || got.done_res != want.done_res ||
                    got.status != want.status ||
                    got.reinit_request != want.reinit_request ||
                    got.wait_events != want.wait_events || got.pad != want.pad) begin
                    n_errors++;
                    if (n_errors <= 10) begin
                        $display("ERROR: result mismatch expected %h actual %h", want, got);
                    end
                end
            end
        end
    end

    int idle_cycles;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles = 0;
        end else if ((i_s_axis_tvalid && o_s_axis_tready) ||
                     (o_m_axis_tvalid && i_m_axis_tready)) begin
            idle_cycles = 0;
        end else if (i_s_axis_tvalid || expected_results.size() > 0) begin
            idle_cycles++;
            if (idle_cycles >= WDOG_LIMIT) begin
                $display("ERROR: no progress for %0d cycles", WDOG_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = '0;
        quiet           = 1'b0;
        hold_req        = 1'b0;
        n_items = 0; n_results = 0; n_cmds = 0; n_rx = 0; n_done = 0; n_errors = 0;
        end_transfer(ST_OK, 1'b0);
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_ring_preload();
        test_directed();
        test_list_overflow();
        test_backpressure();
        test_random();
        i_s_axis_tvalid <= 1'b0;
        while (expected_results.size() > 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (expected_results.size() > 0) n_errors++;
        $display("Sent %0d requests; checked %0d results: %0d commands, %0d rx bytes,",
                 n_items, n_results, n_cmds, n_rx);
        $display("%0d completions, including aborts, a full list and a long output stall.",
                 n_done);
        if (n_errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Mismatches: %0d", n_errors);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
